// ===== sv/lurj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurj_pkg
// Shared sizes, codes and control structs of the journaled list.
// ----------------------------------------------------------------------------
package lurj_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int HIST_DEPTH = 16;
	localparam int DATA_WIDTH = 32;

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W  = $clog2(LIST_DEPTH);
	localparam int SLOT_W = $clog2(HIST_DEPTH);
	localparam int HCNT_W = $clog2(HIST_DEPTH + 1);

	typedef enum logic [3:0] {
		F_SET        = 4'd0,
		F_PUSH_BACK  = 4'd1,
		F_PUSH_FRONT = 4'd2,
		F_POP_BACK   = 4'd3,
		F_POP_FRONT  = 4'd4,
		F_INSERT     = 4'd5,
		F_ERASE      = 4'd6,
		F_CLEAR      = 4'd7,
		F_GET        = 4'd8,
		F_SIZE       = 4'd9,
		F_UNDO       = 4'd10,
		F_REDO       = 4'd11
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD     = 2'd1,
		ST_NO_UNDO = 2'd2,
		ST_NO_REDO = 2'd3
	} status_t;

	typedef struct packed {
		logic             load;
		logic             exec;
		logic             copy;
		logic             rd_en;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic need_copy;
		logic need_restore;
	} sts_t;

endpackage

// ===== sv/list_with_undo_redo_journal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_with_undo_redo_journal
// Bounded list with an undo/redo journal of edits; clear keeps a full copy.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   func, position, new_value
// out      source     out_valid/out_stall read_value, length, status
//
// The item is executed on the edge after it is accepted and its result is
// valid right after, but for a clear, which first copies the list into the
// snapshot memory, and an undo of a clear, which first reads it back over
// its single read port. Insert and erase shift the whole list in parallel
// as the item executes. One item is in flight; in_stall stays high until
// its result is taken. Reset clears state, counts and pointers only.
// ----------------------------------------------------------------------------
module list_with_undo_redo_journal (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [4:0]  position,
	input  logic [31:0] new_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic [4:0]  length,
	output logic [1:0]  status
);
	import lurj_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lurj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lurj_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.position   (position),
		.new_value  (new_value),
		.read_value (read_value),
		.length     (length),
		.status     (status)
	);

endmodule

// ===== sv/lurj_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurj_ctrl
// Sequencer: accept, execute, snapshot copy or restore, result handoff.
// ----------------------------------------------------------------------------
module lurj_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  lurj_pkg::sts_t sts,
	output lurj_pkg::cmd_t cmd
);
	import lurj_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_EXEC    = 4'b0010,
		S_COPY    = 4'b0100,
		S_RESTORE = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] step_q;
	logic             out_valid_q;
	logic             accept;
	logic             finish;

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		finish = 1'b0;
		unique case (state_q)
			S_EXEC:    finish = !sts.need_copy && !sts.need_restore;
			S_COPY:    finish = (step_q == CNT_W'(LIST_DEPTH - 1));
			S_RESTORE: finish = (step_q == CNT_W'(LIST_DEPTH));
			default:   finish = 1'b0;
		endcase
	end

	always_comb begin
		cmd.load  = accept;
		cmd.exec  = (state_q == S_EXEC);
		cmd.copy  = (state_q == S_COPY);
		cmd.rd_en = (state_q == S_RESTORE) && (step_q < CNT_W'(LIST_DEPTH));
		cmd.step  = step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (finish)
				out_valid_q <= 1'b1;
			unique case (state_q) inside
				S_IDLE: begin
					step_q <= '0;
					if (accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					step_q <= '0;
					if (sts.need_copy)
						state_q <= S_COPY;
					else if (sts.need_restore)
						state_q <= S_RESTORE;
					else
						state_q <= S_IDLE;
				end
				S_COPY, S_RESTORE: begin
					step_q <= step_q + 1'b1;
					if (finish)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/lurj_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lurj_dp
// List registers, edit journal ring, snapshot memory and result registers.
// ----------------------------------------------------------------------------
module lurj_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  lurj_pkg::cmd_t cmd,
	output lurj_pkg::sts_t sts,
	input  logic [3:0]     func,
	input  logic [4:0]     position,
	input  logic [31:0]    new_value,
	output logic [31:0]    read_value,
	output logic [4:0]     length,
	output logic [1:0]     status
);
	import lurj_pkg::*;

	typedef logic [DATA_WIDTH-1:0] data_t;

	// latched item
	logic [3:0] func_q;
	logic [4:0] pos_q;
	data_t      val_q;

	// list
	data_t            elem_q [LIST_DEPTH];
	data_t            elem_n [LIST_DEPTH];
	logic [CNT_W-1:0] cnt_q, cnt_n;

	// journal
	func_t             h_kind_q [HIST_DEPTH];
	logic [CNT_W-1:0]  h_idx_q  [HIST_DEPTH];
	data_t             h_old_q  [HIST_DEPTH];
	data_t             h_new_q  [HIST_DEPTH];
	logic [CNT_W-1:0]  snap_len_q [HIST_DEPTH];
	logic [SLOT_W-1:0] oldest_q, oldest_n;
	logic [HCNT_W-1:0] cur_q, cur_n, top_q, top_n;

	// snapshot memory
	data_t                   snap_mem [HIST_DEPTH * LIST_DEPTH];
	logic [SLOT_W-1:0]       snap_slot_q, snap_slot_n;
	data_t                   snap_rd_s1;
	logic                    rs_wr_s1;
	logic [IDX_W-1:0]        rs_idx_s1;

	logic [31:0] read_value_q, rd_n;
	logic [4:0]  length_q;
	status_t     status_q, st_n;

	// combinational
	logic [IDX_W-1:0]  ea;
	data_t             e_rd;
	logic [HCNT_W-1:0] rd_k;
	logic [SLOT_W-1:0] rd_slot, j_slot;
	logic [HCNT_W-1:0] j_top;
	logic [SLOT_W-1:0] j_oldest;
	logic              j_en;
	func_t             j_kind;
	logic [CNT_W-1:0]  j_idx;
	data_t             j_old, j_new;
	logic              rp_en, rp_fwd;
	logic              put_en, take_en, set_en;
	logic [CNT_W-1:0]  put_idx, take_idx, set_idx;
	data_t             put_val, set_val;
	logic              put_ok, take_ok;
	logic              clr, need_copy, need_restore;
	func_t             h_kind;
	logic [CNT_W-1:0]  h_idx;
	data_t             h_old, h_new;
	logic              pos_lt, pos_le, not_full, not_empty;

	function automatic logic [SLOT_W-1:0] wrap(input logic [SLOT_W-1:0] base,
	                                           input logic [HCNT_W-1:0] k);
		logic [HCNT_W:0] s;
		s = (HCNT_W + 1)'(base) + (HCNT_W + 1)'(k);
		if (s >= (HCNT_W + 1)'(HIST_DEPTH))
			s = s - (HCNT_W + 1)'(HIST_DEPTH);
		return s[SLOT_W-1:0];
	endfunction

	assign pos_lt    = 32'(pos_q) < 32'(cnt_q);
	assign pos_le    = 32'(pos_q) <= 32'(cnt_q);
	assign not_full  = cnt_q < CNT_W'(LIST_DEPTH);
	assign not_empty = cnt_q != '0;

	// single element read port
	always_comb begin
		ea = pos_q[IDX_W-1:0];
		if (cmd.copy)
			ea = cmd.step[IDX_W-1:0];
		else if (func_q == F_POP_BACK)
			ea = IDX_W'(cnt_q - 1'b1);
		else if (func_q == F_POP_FRONT)
			ea = '0;
	end
	assign e_rd = elem_q[ea];

	assign rd_k    = (func_q == F_UNDO) ? cur_q - 1'b1 : cur_q;
	assign rd_slot = wrap(oldest_q, rd_k);
	assign h_kind  = h_kind_q[rd_slot];
	assign h_idx   = h_idx_q[rd_slot];
	assign h_old   = h_old_q[rd_slot];
	assign h_new   = h_new_q[rd_slot];

	// journal slot
	always_comb begin
		if (cur_q >= HCNT_W'(HIST_DEPTH)) begin
			j_oldest = wrap(oldest_q, HCNT_W'(1));
			j_top    = HCNT_W'(HIST_DEPTH - 1);
		end else begin
			j_oldest = oldest_q;
			j_top    = cur_q;
		end
		j_slot = wrap(j_oldest, j_top);
	end

	// operation decode
	always_comb begin
		j_en = 1'b0; j_kind = F_SET; j_idx = '0; j_old = '0; j_new = '0;
		rp_en = 1'b0; rp_fwd = 1'b0;
		put_en = 1'b0; put_idx = '0; put_val = '0;
		take_en = 1'b0; take_idx = '0;
		set_en = 1'b0; set_idx = '0; set_val = '0;
		clr = 1'b0; need_copy = 1'b0; need_restore = 1'b0;
		rd_n = '0; st_n = ST_OK;
		oldest_n = oldest_q; cur_n = cur_q; top_n = top_q;
		snap_slot_n = snap_slot_q;
		unique case (func_q) inside
			F_SET: begin
				if (pos_lt) begin
					j_en = 1'b1; j_kind = F_SET; j_idx = CNT_W'(pos_q);
					j_old = e_rd; j_new = val_q;
					set_en = 1'b1; set_idx = CNT_W'(pos_q); set_val = val_q;
				end else st_n = ST_BAD;
			end
			F_PUSH_BACK, F_PUSH_FRONT: begin
				if (not_full) begin
					j_en = 1'b1; j_kind = func_t'(func_q);
					j_idx = (func_q == F_PUSH_BACK) ? cnt_q : '0;
					j_new = val_q;
					put_en = 1'b1; put_idx = j_idx; put_val = val_q;
				end else st_n = ST_BAD;
			end
			F_POP_BACK, F_POP_FRONT: begin
				if (not_empty) begin
					j_en = 1'b1; j_kind = func_t'(func_q);
					j_idx = (func_q == F_POP_BACK) ? cnt_q - 1'b1 : '0;
					j_old = e_rd;
					take_en = 1'b1; take_idx = j_idx;
				end else st_n = ST_BAD;
			end
			F_INSERT: begin
				if (not_full && pos_le) begin
					j_en = 1'b1; j_kind = F_INSERT; j_idx = CNT_W'(pos_q); j_new = val_q;
					put_en = 1'b1; put_idx = CNT_W'(pos_q); put_val = val_q;
				end else st_n = ST_BAD;
			end
			F_ERASE: begin
				if (pos_lt) begin
					j_en = 1'b1; j_kind = F_ERASE; j_idx = CNT_W'(pos_q); j_old = e_rd;
					take_en = 1'b1; take_idx = CNT_W'(pos_q);
				end else st_n = ST_BAD;
			end
			F_CLEAR: begin
				j_en = 1'b1; j_kind = F_CLEAR;
				clr = 1'b1; need_copy = 1'b1; snap_slot_n = j_slot;
			end
			F_GET: begin
				if (pos_lt) rd_n = 32'(e_rd);
				else st_n = ST_BAD;
			end
			F_SIZE: ;
			F_UNDO: begin
				if (cur_q != '0) begin
					cur_n = cur_q - 1'b1; rp_en = 1'b1; rp_fwd = 1'b0;
				end else st_n = ST_NO_UNDO;
			end
			F_REDO: begin
				if (cur_q < top_q) begin
					cur_n = cur_q + 1'b1; rp_en = 1'b1; rp_fwd = 1'b1;
				end else st_n = ST_NO_REDO;
			end
			default: st_n = ST_BAD;
		endcase

		if (j_en) begin
			oldest_n = j_oldest;
			top_n    = j_top + 1'b1;
			cur_n    = j_top + 1'b1;
		end

		if (rp_en) begin
			unique case (h_kind)
				F_SET: begin
					if (h_idx < cnt_q) begin
						set_en = 1'b1; set_idx = h_idx; set_val = rp_fwd ? h_new : h_old;
					end
				end
				F_PUSH_BACK: begin
					if (rp_fwd) begin put_en = 1'b1; put_idx = cnt_q; put_val = h_new; end
					else begin take_en = 1'b1; take_idx = cnt_q - 1'b1; end
				end
				F_PUSH_FRONT: begin
					if (rp_fwd) begin put_en = 1'b1; put_val = h_new; end
					else take_en = 1'b1;
				end
				F_POP_BACK: begin
					if (rp_fwd) begin take_en = 1'b1; take_idx = cnt_q - 1'b1; end
					else begin put_en = 1'b1; put_idx = cnt_q; put_val = h_old; end
				end
				F_POP_FRONT: begin
					if (rp_fwd) take_en = 1'b1;
					else begin put_en = 1'b1; put_val = h_old; end
				end
				F_INSERT: begin
					if (rp_fwd) begin put_en = 1'b1; put_idx = h_idx; put_val = h_new; end
					else begin take_en = 1'b1; take_idx = h_idx; end
				end
				F_ERASE: begin
					if (rp_fwd) begin take_en = 1'b1; take_idx = h_idx; end
					else begin put_en = 1'b1; put_idx = h_idx; put_val = h_old; end
				end
				F_CLEAR: begin
					if (rp_fwd) clr = 1'b1;
					else begin need_restore = 1'b1; snap_slot_n = rd_slot; end
				end
				default: ;
			endcase
		end
	end

	assign put_ok  = put_en && (cnt_q < CNT_W'(LIST_DEPTH)) && (put_idx <= cnt_q);
	assign take_ok = take_en && (take_idx < cnt_q);

	// parallel shift of the list
	always_comb begin
		elem_n = elem_q;
		cnt_n  = cnt_q;
		if (put_ok) begin
			for (int j = 1; j < LIST_DEPTH; j++)
				if (j > int'(put_idx) && j <= int'(cnt_q))
					elem_n[j] = elem_q[j-1];
			elem_n[put_idx[IDX_W-1:0]] = put_val;
			cnt_n = cnt_q + 1'b1;
		end
		if (take_ok) begin
			for (int j = 0; j < LIST_DEPTH - 1; j++)
				if (j >= int'(take_idx) && j < int'(cnt_q) - 1)
					elem_n[j] = elem_q[j+1];
			cnt_n = cnt_q - 1'b1;
		end
		if (set_en)
			elem_n[set_idx[IDX_W-1:0]] = set_val;
		if (clr)
			cnt_n = '0;
		if (need_restore)
			cnt_n = snap_len_q[rd_slot];
	end

	assign sts.need_copy    = cmd.exec && need_copy;
	assign sts.need_restore = cmd.exec && need_restore;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			oldest_q <= '0;
			cur_q    <= '0;
			top_q    <= '0;
			rs_wr_s1 <= 1'b0;
		end else begin
			rs_wr_s1 <= cmd.rd_en;
			if (cmd.exec) begin
				cnt_q    <= cnt_n;
				oldest_q <= oldest_n;
				cur_q    <= cur_n;
				top_q    <= top_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= DATA_WIDTH'(new_value);
		end
		if (cmd.exec) begin
			elem_q       <= elem_n;
			snap_slot_q  <= snap_slot_n;
			read_value_q <= rd_n;
			length_q     <= 5'(cnt_n);
			status_q     <= st_n;
			if (j_en) begin
				h_kind_q[j_slot] <= j_kind;
				h_idx_q[j_slot]  <= j_idx;
				h_old_q[j_slot]  <= j_old;
				h_new_q[j_slot]  <= j_new;
				if (j_kind == F_CLEAR)
					snap_len_q[j_slot] <= cnt_q;
			end
		end else if (rs_wr_s1) begin
			elem_q[rs_idx_s1] <= snap_rd_s1;
		end
	end

	// snapshot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.copy)
			snap_mem[{snap_slot_q, cmd.step[IDX_W-1:0]}] <= e_rd;
		if (cmd.rd_en) begin
			snap_rd_s1 <= snap_mem[{snap_slot_q, cmd.step[IDX_W-1:0]}];
			rs_idx_s1  <= cmd.step[IDX_W-1:0];
		end
	end

	assign read_value = read_value_q;
	assign length     = length_q;
	assign status     = status_q;

endmodule

// ===== tb/list_with_undo_redo_journal_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_with_undo_redo_journal_test
// Drives list operations, undo and redo into the journaled list, predicts each
// result with a behavioral copy of the list and its journal, and checks every
// returned item field by field. Random gaps on both sides, one long output
// stall.
// ----------------------------------------------------------------------------
module list_with_undo_redo_journal_test;
	import lurj_pkg::*;

	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [31:0] read_value;
		logic [4:0]  length;
		logic [1:0]  status;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  func = '0;
	logic [4:0]  position = '0;
	logic [31:0] new_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_value;
	logic [4:0]  length;
	logic [1:0]  status;

	list_with_undo_redo_journal u_top (.*);

	always #4 clk = ~clk;

	// model of the list and its journal
	logic [31:0] lst [LIST_DEPTH];
	int          cnt;
	logic [3:0]  j_kind [HIST_DEPTH];
	int          j_idx [HIST_DEPTH];
	logic [31:0] j_old [HIST_DEPTH];
	logic [31:0] j_new [HIST_DEPTH];
	logic [31:0] snap [HIST_DEPTH][LIST_DEPTH];
	int          snap_len [HIST_DEPTH];
	int          oldest, cursor, top;

	reply_t replies_due [$];
	int     errors = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     cycles = 0;
	bit     hold_off = 1'b0;
	bit     busy_out = 1'b1;

	task automatic put_at(input int idx, input logic [31:0] v);
		if (cnt >= LIST_DEPTH || idx > cnt) return;
		for (int i = cnt; i > idx; i--) lst[i] = lst[i-1];
		lst[idx] = v;
		cnt++;
	endtask

	task automatic take_at(input int idx);
		if (idx < 0 || idx >= cnt) return;
		for (int i = idx; i < cnt - 1; i++) lst[i] = lst[i+1];
		cnt--;
	endtask

	task automatic journal(input logic [3:0] k, input int idx, input logic [31:0] ov,
			input logic [31:0] nv);
		int s;
		top = cursor;
		if (top >= HIST_DEPTH) begin
			oldest = (oldest + 1) % HIST_DEPTH;
			top = HIST_DEPTH - 1;
		end
		s = (oldest + top) % HIST_DEPTH;
		j_kind[s] = k; j_idx[s] = idx; j_old[s] = ov; j_new[s] = nv;
		if (k == F_CLEAR) begin
			for (int i = 0; i < LIST_DEPTH; i++) snap[s][i] = lst[i];
			snap_len[s] = cnt;
		end
		top++;
		cursor = top;
	endtask

	task automatic replay(input int s, input bit fwd);
		case (j_kind[s])
			F_SET: if (j_idx[s] < cnt) lst[j_idx[s]] = fwd ? j_new[s] : j_old[s];
			F_PUSH_BACK: if (fwd) put_at(cnt, j_new[s]); else take_at(cnt - 1);
			F_PUSH_FRONT: if (fwd) put_at(0, j_new[s]); else take_at(0);
			F_POP_BACK: if (fwd) take_at(cnt - 1); else put_at(cnt, j_old[s]);
			F_POP_FRONT: if (fwd) take_at(0); else put_at(0, j_old[s]);
			F_INSERT: if (fwd) put_at(j_idx[s], j_new[s]); else take_at(j_idx[s]);
			F_ERASE: if (fwd) take_at(j_idx[s]); else put_at(j_idx[s], j_old[s]);
			F_CLEAR: begin
				if (fwd) cnt = 0;
				else begin
					for (int i = 0; i < LIST_DEPTH; i++) lst[i] = snap[s][i];
					cnt = snap_len[s];
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [31:0] safe_rd(input int i);
		// never-written slots read as zero (the stimulus avoids them anyway)
		return (lst[i] === 'x) ? '0 : lst[i];
	endfunction

	task automatic predict_reply(input logic [3:0] f, input int p, input logic [31:0] v);
		reply_t r;
		r = '0;
		r.status = ST_OK;
		case (f)
			F_SET: if (p < cnt) begin journal(F_SET, p, lst[p], v); lst[p] = v; end
				else r.status = ST_BAD;
			F_PUSH_BACK: if (cnt < LIST_DEPTH) begin
				journal(F_PUSH_BACK, cnt, '0, v); put_at(cnt, v);
			end else r.status = ST_BAD;
			F_PUSH_FRONT: if (cnt < LIST_DEPTH) begin
				journal(F_PUSH_FRONT, 0, '0, v); put_at(0, v);
			end else r.status = ST_BAD;
			F_POP_BACK: if (cnt > 0) begin
				journal(F_POP_BACK, cnt - 1, lst[cnt-1], '0); take_at(cnt - 1);
			end else r.status = ST_BAD;
			F_POP_FRONT: if (cnt > 0) begin
				journal(F_POP_FRONT, 0, lst[0], '0); take_at(0);
			end else r.status = ST_BAD;
			F_INSERT: if (cnt < LIST_DEPTH && p <= cnt) begin
				journal(F_INSERT, p, '0, v); put_at(p, v);
			end else r.status = ST_BAD;
			F_ERASE: if (p < cnt) begin journal(F_ERASE, p, lst[p], '0); take_at(p); end
				else r.status = ST_BAD;
			F_CLEAR: begin journal(F_CLEAR, 0, '0, '0); cnt = 0; end
			F_GET: if (p < cnt) r.read_value = safe_rd(p); else r.status = ST_BAD;
			F_SIZE: ;
			F_UNDO: if (cursor > 0) begin
				cursor--; replay((oldest + cursor) % HIST_DEPTH, 1'b0);
			end else r.status = ST_NO_UNDO;
			F_REDO: if (cursor < top) begin
				replay((oldest + cursor) % HIST_DEPTH, 1'b1); cursor++;
			end else r.status = ST_NO_REDO;
			default: r.status = ST_BAD;
		endcase
		r.length = cnt[4:0];
		replies_due = {replies_due, r};
	endtask

	// valid stays high after an accept only until the next call decides on a gap
	task automatic send_item(input logic [3:0] f, input logic [4:0] p, input logic [31:0] v,
			input bit gaps = 1'b1);
		int gap;
		gap = gaps ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		new_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_reply(f, int'(p), v);
		n_sent++;
	endtask

	// result checker and receiver idling
	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected item: read_value %h length %0d status %0d",
					$time, read_value, length, status);
				errors++;
			end else begin
				exp_r = replies_due[0];
				replies_due.delete(0);
				if (read_value !== exp_r.read_value) begin
					$display("%0t: read_value expected %h actual %h", $time,
						exp_r.read_value, read_value);
					errors++;
				end
				if (length !== exp_r.length) begin
					$display("%0t: length expected %0d actual %0d", $time,
						exp_r.length, length);
					errors++;
				end
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, status);
					errors++;
				end
			end
		end
	end

	initial begin
		int w;
		forever begin
			@(posedge clk);
			if (hold_off) out_stall <= 1'b1;
			else if (busy_out) begin
				w = $urandom_range(0, 10);
				out_stall <= (w != 0);
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end else out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		// errors on an empty list and empty journal
		send_item(F_POP_BACK, 5'd0, 32'h0);
		send_item(F_POP_FRONT, 5'd0, 32'h0);
		send_item(F_UNDO, 5'd0, 32'h0);
		send_item(F_REDO, 5'd0, 32'h0);
		send_item(F_GET, 5'd0, 32'h0);
		send_item(F_ERASE, 5'd0, 32'h0);
		send_item(F_INSERT, 5'd1, 32'h0);
		send_item(4'd12, 5'd0, 32'h1);
		send_item(4'd15, 5'd31, 32'hffff_ffff);
		send_item(F_CLEAR, 5'd0, 32'h0);                 // clear of an empty list
		send_item(F_PUSH_BACK, 5'd0, 32'h8000_0000);
		send_item(F_PUSH_FRONT, 5'd0, 32'h7fff_ffff);
		send_item(F_INSERT, 5'd1, 32'hffff_ffff);
		send_item(F_SET, 5'd2, 32'h1234_5678);
		send_item(F_SET, 5'd3, 32'h1);
		send_item(F_GET, 5'd2, 32'h0);
		send_item(F_SIZE, 5'd31, 32'h0);
		send_item(F_ERASE, 5'd0, 32'h0);
		send_item(F_CLEAR, 5'd0, 32'h0);
		send_item(F_UNDO, 5'd0, 32'h0);
		send_item(F_GET, 5'd1, 32'h0);
		send_item(F_REDO, 5'd0, 32'h0);
		send_item(F_UNDO, 5'd0, 32'h0);
		send_item(F_POP_FRONT, 5'd0, 32'h0);
		send_item(F_POP_BACK, 5'd0, 32'h0);
	endtask

	task automatic test_fill_and_wrap();
		// fill to full, overflow, then more than a journal's worth of edits
		for (int i = 0; i < 17; i++) send_item(F_PUSH_BACK, 5'd0, $urandom, 1'b0);
		send_item(F_INSERT, 5'd0, 32'h5);
		send_item(F_GET, 5'd15, 32'h0);
		send_item(F_GET, 5'd16, 32'h0);
		for (int i = 0; i < 20; i++) send_item(F_SET, 5'(i % 16), $urandom, 1'b0);
		for (int i = 0; i < 18; i++) send_item(F_UNDO, 5'd0, 32'h0, 1'b0);
		for (int i = 0; i < 18; i++) send_item(F_REDO, 5'd0, 32'h0, 1'b0);
	endtask

	task automatic test_backpressure();
		// receiver stops for a long time while items keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 8; i++) send_item(F_PUSH_FRONT, 5'd0, $urandom, 1'b0);
		join
	endtask

	task automatic test_random(input int n);
		logic [3:0] f;
		logic [4:0] p;
		int         k;
		for (int i = 0; i < n; i++) begin
			busy_out = ($urandom_range(0, 9) != 0);
			k = $urandom_range(0, 99);
			if (k < 3) f = 4'($urandom_range(12, 15));
			else if (k < 6) f = F_CLEAR;
			else if (k < 22) f = F_UNDO;
			else if (k < 32) f = F_REDO;
			else if (k < 48) f = (cnt < 12) ? F_PUSH_BACK : F_POP_FRONT;
			else f = 4'($urandom_range(0, 9));
			if ($urandom_range(0, 9) == 0) p = 5'($urandom);
			else p = 5'($urandom_range(0, (cnt > 0) ? cnt : 0));
			send_item(f, p, rnd_val(), $urandom_range(0, 3) != 0);
		end
		busy_out = 1'b1;
	endtask

	initial begin
		cnt = 0; oldest = 0; cursor = 0; top = 0;
		for (int i = 0; i < HIST_DEPTH; i++) snap_len[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_wrap();
		test_backpressure();
		test_random(1040);
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d items, checked %0d results: all operations, errors,", n_sent,
			n_checked);
		$display("journal wrap, clear snapshots and a long output stall.");
		if (errors == 0 && replies_due.size() == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
